[rtl/core/tls_pkg.sv]
// tls_pkg: shared types and constants of the text line splitter
// used by tls_step, tls_queue and text_line_splitter; no dependencies
package tls_pkg;

   // terminator characters
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_CR = 8'h0D;

   // configuration port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 48;
   localparam int RANGE_BITS     = 48;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SKIP_FIRST_LINE = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RANGE_BYTES     = 2'd1;

   // result fields of fixed width
   localparam int OUT_LEN_BITS = 32;
   localparam int ROW_BITS     = 32;

   // result queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      PH_BETWEEN = 2'd0,
      PH_SKIP    = 2'd1,
      PH_LINE    = 2'd2,
      PH_DONE    = 2'd3
   } phase_type;

   typedef struct packed {
      logic [7:0]              out_byte;
      logic                    has_byte;
      logic                    line_end;
      logic [OUT_LEN_BITS-1:0] line_length;
      logic [ROW_BITS-1:0]     row_number;
      logic                    run_last;
   } result_type;

endpackage

[rtl/core/text_line_splitter.sv]
// text_line_splitter: top level, state registers, config port and result queue
// depends on tls_pkg, tls_step and tls_queue
//
// Splits a byte stream into lines ending in LF or CR LF, one item accepted per
// clock while req_ready is high. Each byte yields zero, one or two result
// items; the rsp channel carries one result at a time, so a byte that yields
// two results (a held CR followed by a content byte) holds the output for both.
// Results go through a four-entry queue; req_ready is high while at most two
// results are held, so the input keeps flowing at one byte per cycle as long
// as the output drains and most bytes give a single result. Results of an
// accepted byte are registered in the queue. Write registers through csr_we
// only while no item is in flight; the block itself does not enforce this.
module text_line_splitter #(
   parameter int LENGTH_BITS = 32,
   parameter int COUNT_BITS  = 48
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [tls_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [tls_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [7:0]                           req_in_byte,
   input  logic                                 req_in_last,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [7:0]                           rsp_out_byte,
   output logic                                 rsp_has_byte,
   output logic                                 rsp_line_end,
   output logic [tls_pkg::OUT_LEN_BITS-1:0]     rsp_line_length,
   output logic [tls_pkg::ROW_BITS-1:0]         rsp_row_number,
   output logic                                 rsp_run_last
);

   logic [tls_pkg::RANGE_BITS-1:0] range_ff;
   tls_pkg::phase_type             phase_ff, phase_in;
   logic                           cr_pending_ff, cr_pending_in;
   logic [LENGTH_BITS-1:0]         line_len_ff, line_len_in;
   logic [COUNT_BITS-1:0]          consumed_ff, consumed_in;
   logic [tls_pkg::ROW_BITS-1:0]   row_ff, row_in;
   tls_pkg::result_type            res0;
   tls_pkg::result_type            res1;
   tls_pkg::result_type            head;
   logic [1:0]                     res_count;
   logic [1:0]                     push_count;
   logic                           room;
   logic                           accept;

   assign req_ready  = room;
   assign accept     = req_valid && room;
   assign push_count = accept ? res_count : 2'd0;

   // per-byte logic
   tls_step #(
      .LENGTH_BITS (LENGTH_BITS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_step (
      .in_byte       (req_in_byte),
      .in_last       (req_in_last),
      .range_bytes   (range_ff),
      .phase         (phase_ff),
      .cr_pending    (cr_pending_ff),
      .line_len      (line_len_ff),
      .consumed      (consumed_ff),
      .row           (row_ff),
      .phase_nx      (phase_in),
      .cr_pending_nx (cr_pending_in),
      .line_len_nx   (line_len_in),
      .consumed_nx   (consumed_in),
      .row_nx        (row_in),
      .res0          (res0),
      .res1          (res1),
      .res_count     (res_count)
   );

   // configuration and line state
   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff      <= '0;
         phase_ff      <= tls_pkg::PH_BETWEEN;
         cr_pending_ff <= 1'b0;
         line_len_ff   <= '0;
         consumed_ff   <= '0;
         row_ff        <= '0;
      end else begin
         if (accept) begin
            phase_ff      <= phase_in;
            cr_pending_ff <= cr_pending_in;
            line_len_ff   <= line_len_in;
            consumed_ff   <= consumed_in;
            row_ff        <= row_in;
         end
         if (csr_we) begin
            unique case (csr_index)
               tls_pkg::CSR_SKIP_FIRST_LINE: begin
                  // skip setting only takes hold before the first byte
                  if (!accept && (consumed_ff == '0) &&
                      ((phase_ff == tls_pkg::PH_BETWEEN) ||
                       (phase_ff == tls_pkg::PH_SKIP))) begin
                     phase_ff <= csr_wdata[0] ? tls_pkg::PH_SKIP
                                              : tls_pkg::PH_BETWEEN;
                  end
               end
               tls_pkg::CSR_RANGE_BYTES: begin
                  range_ff <= csr_wdata[tls_pkg::RANGE_BITS-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   // result queue
   tls_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push0      (res0),
      .push1      (res1),
      .push_count (push_count),
      .room       (room),
      .head       (head),
      .head_valid (rsp_valid),
      .head_ready (rsp_ready)
   );

   assign rsp_out_byte    = head.out_byte;
   assign rsp_has_byte    = head.has_byte;
   assign rsp_line_end    = head.line_end;
   assign rsp_line_length = head.line_length;
   assign rsp_row_number  = head.row_number;
   assign rsp_run_last    = head.run_last;

endmodule

[rtl/core/tls_step.sv]
// tls_step: per-byte next-state and result logic of the line splitter
// depends on tls_pkg; purely combinational, fed from the state registers
module tls_step #(
   parameter int LENGTH_BITS = 32,
   parameter int COUNT_BITS  = 48
) (
   input  logic [7:0]                   in_byte,
   input  logic                         in_last,
   input  logic [tls_pkg::RANGE_BITS-1:0] range_bytes,
   input  tls_pkg::phase_type           phase,
   input  logic                         cr_pending,
   input  logic [LENGTH_BITS-1:0]       line_len,
   input  logic [COUNT_BITS-1:0]        consumed,
   input  logic [tls_pkg::ROW_BITS-1:0] row,
   output tls_pkg::phase_type           phase_nx,
   output logic                         cr_pending_nx,
   output logic [LENGTH_BITS-1:0]       line_len_nx,
   output logic [COUNT_BITS-1:0]        consumed_nx,
   output logic [tls_pkg::ROW_BITS-1:0] row_nx,
   output tls_pkg::result_type          res0,
   output tls_pkg::result_type          res1,
   output logic [1:0]                   res_count
);

   localparam int CMP_BITS = (COUNT_BITS > tls_pkg::RANGE_BITS) ? COUNT_BITS
                                                                : tls_pkg::RANGE_BITS;
   localparam int EXT_BITS = (LENGTH_BITS > tls_pkg::OUT_LEN_BITS) ? LENGTH_BITS
                                                                   : tls_pkg::OUT_LEN_BITS + 1;

   function automatic logic [LENGTH_BITS-1:0] len_inc(input logic [LENGTH_BITS-1:0] v);
      return (&v) ? v : v + LENGTH_BITS'(1);
   endfunction

   function automatic logic [tls_pkg::OUT_LEN_BITS-1:0] len_out(
      input logic [LENGTH_BITS-1:0] v);
      logic [EXT_BITS-1:0] ext;
      ext = EXT_BITS'(v);
      return (|ext[EXT_BITS-1:tls_pkg::OUT_LEN_BITS]) ? '1
                                                      : ext[tls_pkg::OUT_LEN_BITS-1:0];
   endfunction

   logic                   is_lf;
   logic                   is_cr;
   logic                   range_used;
   logic                   active;
   logic                   cur_cr;
   logic [LENGTH_BITS-1:0] cur_len;
   logic                   cr_emit;
   logic [LENGTH_BITS-1:0] len_a;
   logic [LENGTH_BITS-1:0] len_b;
   logic                   main_emit;
   logic                   main_has;
   logic                   main_end;
   logic [7:0]             main_byte;
   logic [LENGTH_BITS-1:0] main_len;
   tls_pkg::result_type    cr_res;
   tls_pkg::result_type    main_res;

   assign is_lf      = (in_byte == tls_pkg::CH_LF);
   assign is_cr      = (in_byte == tls_pkg::CH_CR);
   assign range_used = (range_bytes != '0) &&
                       (CMP_BITS'(consumed) >= CMP_BITS'(range_bytes));
   assign consumed_nx = (&consumed) ? consumed : consumed + COUNT_BITS'(1);

   // a line is open or about to open with this byte
   assign active  = (phase == tls_pkg::PH_LINE) ||
                    ((phase == tls_pkg::PH_BETWEEN) && !range_used);
   assign cur_cr  = (phase == tls_pkg::PH_LINE) && cr_pending;
   assign cur_len = (phase == tls_pkg::PH_LINE) ? line_len : '0;

   // a held CR not followed by LF becomes content
   assign cr_emit = active && cur_cr && !is_lf;
   assign len_a   = cr_emit ? len_inc(cur_len) : cur_len;
   assign len_b   = len_inc(len_a);

   // result caused by the byte itself
   always_comb begin
      main_emit = 1'b0;
      main_has  = 1'b0;
      main_end  = 1'b0;
      main_byte = 8'h00;
      main_len  = len_a;
      if (active) begin
         if (is_lf) begin
            main_emit = 1'b1;
            main_end  = 1'b1;
         end else if (is_cr) begin
            if (in_last) begin
               main_emit = 1'b1;
               main_has  = 1'b1;
               main_end  = 1'b1;
               main_byte = tls_pkg::CH_CR;
               main_len  = len_b;
            end
         end else begin
            main_emit = 1'b1;
            main_has  = 1'b1;
            main_end  = in_last;
            main_byte = in_byte;
            main_len  = len_b;
         end
      end
   end

   // next state
   always_comb begin
      phase_nx      = phase;
      cr_pending_nx = cr_pending;
      line_len_nx   = line_len;
      row_nx        = row;
      unique case (phase)
         tls_pkg::PH_DONE: begin
         end
         tls_pkg::PH_SKIP: begin
            if (in_last) begin
               phase_nx = tls_pkg::PH_DONE;
            end else if (is_lf) begin
               phase_nx = tls_pkg::PH_BETWEEN;
            end
         end
         default: begin
            if (!active) begin
               phase_nx = tls_pkg::PH_DONE;
            end else if (main_end) begin
               row_nx        = row + tls_pkg::ROW_BITS'(1);
               line_len_nx   = '0;
               cr_pending_nx = 1'b0;
               phase_nx      = in_last ? tls_pkg::PH_DONE : tls_pkg::PH_BETWEEN;
            end else if (is_cr) begin
               cr_pending_nx = 1'b1;
               line_len_nx   = len_a;
               phase_nx      = tls_pkg::PH_LINE;
            end else begin
               cr_pending_nx = 1'b0;
               line_len_nx   = main_len;
               phase_nx      = tls_pkg::PH_LINE;
            end
         end
      endcase
   end

   // result records
   always_comb begin
      cr_res.out_byte    = tls_pkg::CH_CR;
      cr_res.has_byte    = 1'b1;
      cr_res.line_end    = 1'b0;
      cr_res.line_length = '0;
      cr_res.row_number  = row;
      cr_res.run_last    = !main_emit;

      main_res.out_byte    = main_byte;
      main_res.has_byte    = main_has;
      main_res.line_end    = main_end;
      main_res.line_length = main_end ? len_out(main_len) : '0;
      main_res.row_number  = row;
      main_res.run_last    = 1'b1;
   end

   assign res0      = cr_emit ? cr_res : main_res;
   assign res1      = main_res;
   assign res_count = {1'b0, cr_emit} + {1'b0, main_emit};

endmodule

[rtl/core/tls_queue.sv]
// tls_queue: small result queue taking up to two results per cycle
// depends on tls_pkg; drains one result per cycle over valid/ready
module tls_queue (
   input  logic                clock,
   input  logic                reset,
   input  tls_pkg::result_type push0,
   input  tls_pkg::result_type push1,
   input  logic [1:0]          push_count,
   output logic                room,
   output tls_pkg::result_type head,
   output logic                head_valid,
   input  logic                head_ready
);

   tls_pkg::result_type                  mem_ff [tls_pkg::QUEUE_DEPTH];
   logic [tls_pkg::QPTR_BITS-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [tls_pkg::QPTR_BITS-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [tls_pkg::QCNT_BITS-1:0]        count_ff, count_in;
   logic [tls_pkg::QPTR_BITS-1:0]        wr_next;
   logic                                 pop;

   assign wr_next    = wr_ptr_ff + tls_pkg::QPTR_BITS'(1);
   assign pop        = head_valid && head_ready;
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];
   // room for a full two-result item
   assign room       = (count_ff <= tls_pkg::QCNT_BITS'(tls_pkg::QUEUE_DEPTH - 2));

   assign wr_ptr_in = wr_ptr_ff + tls_pkg::QPTR_BITS'(push_count);
   assign rd_ptr_in = rd_ptr_ff + tls_pkg::QPTR_BITS'(pop);
   assign count_in  = count_ff + tls_pkg::QCNT_BITS'(push_count)
                    - tls_pkg::QCNT_BITS'(pop);

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // result storage
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push0;
      end
      if (push_count == 2'd2) begin
         mem_ff[wr_next] <= push1;
      end
   end

endmodule
